// ----- hdl/srs_pkg.sv -----
package srs_pkg;

  localparam int PAYLOAD_WORDS_DEF = 64;
  localparam int WORD_W = 32;
  localparam int HDR_WORDS = 5;

  // slot header layout
  localparam int OFF_MAGIC = 0;
  localparam int OFF_SIZE = 1;
  localparam int OFF_GEN = 2;
  localparam int OFF_CRC = 3;
  localparam int OFF_COMMIT = 4;

  localparam logic [31:0] REC_MAGIC = 32'h4236_4350;
  localparam logic [15:0] REC_VERSION = 16'd3;
  localparam logic [31:0] REC_WRITING = 32'h5752_4954;
  localparam logic [31:0] REC_VALID = 32'h5641_4C44;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_COMMIT = 3'd1,
    OP_SCAN = 3'd2,
    OP_READ = 3'd3,
    OP_RAW = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_NO_VALID = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RESP,
    ST_CM_HDR,
    ST_CM_PAY,
    ST_CM_FIN,
    ST_SC_PASS,
    ST_SC_CHK
  } state_t;

  // scan passes: check slot 1, check slot 0 (copying), copy slot 1
  typedef enum logic [1:0] {
    PASS_S1,
    PASS_S0,
    PASS_CP
  } pass_t;

  typedef struct packed {
    logic we;
    logic clr;
    logic clr_bank;
  } wb_ctl_t;

  typedef struct packed {
    status_t status;
    logic [31:0] read_data;
    logic [31:0] generation;
    logic active_slot;
  } resp_t;

  typedef logic [31:0][63:0] crc_mat_t;

  function automatic int wb_aw(int pw);
    return (pw > 1) ? $clog2(pw) : 1;
  endfunction

  function automatic int sm_aw(int pw);
    return $clog2(4 * (pw + HDR_WORDS));
  endfunction

  // bit-serial reference form, elaboration only
  function automatic logic [31:0] crc_serial(logic [31:0] crc_in, logic [31:0] w);
    logic [31:0] c;
    c = crc_in;
    for (int b = 0; b < 4; b++) begin
      c = c ^ {24'd0, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
    end
    return c;
  endfunction

  // xor matrix of one word step: row j, columns {word, crc}
  function automatic crc_mat_t crc_matrix();
    crc_mat_t m;
    logic [63:0] v;
    logic [31:0] r;
    m = '0;
    for (int col = 0; col < 64; col++) begin
      v = 64'd1 << col;
      r = crc_serial(v[31:0], v[63:32]);
      for (int j = 0; j < 32; j++) begin
        m[j][col] = r[j];
      end
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_matrix();

  function automatic logic [31:0] crc_update(logic [31:0] crc_in, logic [31:0] w);
    logic [31:0] r;
    logic [63:0] x;
    x = {w, crc_in};
    for (int j = 0; j < 32; j++) begin
      r[j] = ^(CRC_MAT[j] & x);
    end
    return r;
  endfunction

endpackage

// ----- hdl/srs_ram.sv -----
module srs_ram #(
  parameter int WIDTH = srs_pkg::WORD_W,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/srs_wbuf.sv -----
module srs_wbuf #(
  parameter int PAYLOAD_WORDS = srs_pkg::PAYLOAD_WORDS_DEF,
  localparam int AW = srs_pkg::wb_aw(PAYLOAD_WORDS) + 1,
  localparam int DEPTH = 2 ** AW
) (
  input  logic              clk,
  input  logic              rst,
  input  srs_pkg::wb_ctl_t  ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);

  // per-entry written flags, an unwritten entry reads as zero
  logic [DEPTH-1:0] vld;
  logic             rvld;
  logic [31:0]      q;

  srs_ram #(
    .WIDTH(srs_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      rvld <= vld[raddr];
      if (ctl.clr) begin
        for (int i = 0; i < DEPTH / 2; i++) begin
          vld[{ctl.clr_bank, (AW-1)'(i)}] <= 1'b0;
        end
      end else if (ctl.we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld ? q : 32'd0;

endmodule

// ----- hdl/srs_engine.sv -----
module srs_engine #(
  parameter int PAYLOAD_WORDS = srs_pkg::PAYLOAD_WORDS_DEF,
  localparam int SLOT_WORDS = PAYLOAD_WORDS + srs_pkg::HDR_WORDS,
  localparam int SM_AW = srs_pkg::sm_aw(PAYLOAD_WORDS),
  localparam int WB_AW = srs_pkg::wb_aw(PAYLOAD_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  // accepted item
  input  logic                 in_valid,
  output logic                 idle,
  input  logic [2:0]           opcode,
  input  logic                 bank,
  input  logic                 slot_select,
  input  logic [6:0]           word_index,
  input  logic [31:0]          data_word,
  // result
  input  logic                 out_free,
  output logic                 resp_load,
  output srs_pkg::resp_t       resp,
  // slot memory
  output logic                 sm_we,
  output logic [SM_AW-1:0]     sm_waddr,
  output logic [31:0]          sm_wdata,
  output logic [SM_AW-1:0]     sm_raddr,
  input  logic [31:0]          sm_rdata,
  // working buffer
  output srs_pkg::wb_ctl_t     wb_ctl,
  output logic [WB_AW:0]       wb_waddr,
  output logic [31:0]          wb_wdata,
  output logic [WB_AW:0]       wb_raddr,
  input  logic [31:0]          wb_rdata
);

  localparam int SCNT_W = $clog2(SLOT_WORDS + 1);
  localparam logic [31:0] SIZE_WORD =
    {16'(PAYLOAD_WORDS * 4), srs_pkg::REC_VERSION};

  srs_pkg::state_t state, state_next;
  srs_pkg::pass_t  pass, pass_next;
  srs_pkg::status_t resp_status, resp_status_next;

  logic [SCNT_W-1:0] cnt, cnt_next, cnt_inc, pay_off;
  logic              arr_vld, arr_vld_next;
  logic [SCNT_W-1:0] arr_off, arr_off_next;
  logic [31:0]       crc, crc_next;
  logic [31:0]       crc_cap, crc_cap_next;
  logic [31:0]       g_cap, g_cap_next;
  logic [31:0]       g1, g1_next;
  logic              ok1, ok1_next;
  logic              hdr_ok, hdr_ok_next;
  logic              copy_en, copy_en_next;
  logic              cur_bank, cur_bank_next;
  logic              cm_slot, cm_slot_next;
  logic [31:0]       resp_rd, resp_rd_next;

  logic [31:0] bank_gen [2];
  logic        bank_slot [2];
  logic        bank_valid [2];

  logic        bank_upd;
  logic [31:0] upd_gen;
  logic        upd_slot;
  logic        upd_valid;

  logic        idx_pay_ok, idx_slot_ok, rec_ok;
  logic [1:0]  rec_cm, rec_sc;
  logic [31:0] gdiff;

  function automatic logic [SM_AW-1:0] sm_addr(logic [1:0] rec, logic [SCNT_W-1:0] off);
    logic [SM_AW-1:0] base;
    case (rec)
      2'd0:    base = '0;
      2'd1:    base = SM_AW'(SLOT_WORDS);
      2'd2:    base = SM_AW'(2 * SLOT_WORDS);
      default: base = SM_AW'(3 * SLOT_WORDS);
    endcase
    return base + SM_AW'(off);
  endfunction

  assign idx_pay_ok  = {1'b0, word_index} < 8'(PAYLOAD_WORDS);
  assign idx_slot_ok = {1'b0, word_index} < 8'(SLOT_WORDS);
  assign rec_ok      = hdr_ok && (~crc == crc_cap);
  assign rec_cm      = {cur_bank, cm_slot};
  assign rec_sc      = {cur_bank, pass != srs_pkg::PASS_S0};
  assign cnt_inc     = cnt + 1'b1;
  assign pay_off     = arr_off - SCNT_W'(srs_pkg::HDR_WORDS);
  assign gdiff       = g1 - sm_rdata;
  assign idle        = state == srs_pkg::ST_IDLE;

  assign resp.status      = resp_status;
  assign resp.read_data   = resp_rd;
  assign resp.generation  = bank_gen[cur_bank];
  assign resp.active_slot = bank_slot[cur_bank];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= srs_pkg::ST_IDLE;
      bank_gen   <= '{default: '0};
      bank_slot  <= '{default: 1'b0};
      bank_valid <= '{default: 1'b0};
      arr_vld    <= 1'b0;
    end else begin
      state   <= state_next;
      arr_vld <= arr_vld_next;
      if (bank_upd) begin
        bank_gen[cur_bank]   <= upd_gen;
        bank_slot[cur_bank]  <= upd_slot;
        bank_valid[cur_bank] <= upd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    pass        <= pass_next;
    resp_status <= resp_status_next;
    cnt         <= cnt_next;
    arr_off     <= arr_off_next;
    crc         <= crc_next;
    crc_cap     <= crc_cap_next;
    g_cap       <= g_cap_next;
    g1          <= g1_next;
    ok1         <= ok1_next;
    hdr_ok      <= hdr_ok_next;
    copy_en     <= copy_en_next;
    cur_bank    <= cur_bank_next;
    cm_slot     <= cm_slot_next;
    resp_rd     <= resp_rd_next;
  end

  always_comb begin
    state_next       = state;
    pass_next        = pass;
    resp_status_next = resp_status;
    cnt_next         = cnt;
    arr_vld_next     = 1'b0;
    arr_off_next     = arr_off;
    crc_next         = crc;
    crc_cap_next     = crc_cap;
    g_cap_next       = g_cap;
    g1_next          = g1;
    ok1_next         = ok1;
    hdr_ok_next      = hdr_ok;
    copy_en_next     = copy_en;
    cur_bank_next    = cur_bank;
    cm_slot_next     = cm_slot;
    resp_rd_next     = resp_rd;
    resp_load        = 1'b0;
    bank_upd         = 1'b0;
    upd_gen          = '0;
    upd_slot         = 1'b0;
    upd_valid        = 1'b0;
    sm_we            = 1'b0;
    sm_waddr         = '0;
    sm_wdata         = '0;
    sm_raddr         = '0;
    wb_ctl           = '0;
    wb_waddr         = '0;
    wb_wdata         = '0;
    wb_raddr         = '0;

    case (state)
      srs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_bank_next    = bank;
          resp_status_next = srs_pkg::STAT_DONE;
          resp_rd_next     = '0;
          cnt_next         = '0;
          state_next       = srs_pkg::ST_RESP;
          case (opcode)
            srs_pkg::OP_LOAD: begin
              if (idx_pay_ok) begin
                wb_ctl.we = 1'b1;
                wb_waddr  = {bank, word_index[WB_AW-1:0]};
                wb_wdata  = data_word;
              end else begin
                resp_status_next = srs_pkg::STAT_RANGE;
              end
            end
            srs_pkg::OP_READ: begin
              if (idx_pay_ok) begin
                wb_raddr   = {bank, word_index[WB_AW-1:0]};
                state_next = srs_pkg::ST_RD;
              end else begin
                resp_status_next = srs_pkg::STAT_RANGE;
              end
            end
            srs_pkg::OP_RAW: begin
              if (idx_slot_ok) begin
                sm_we    = 1'b1;
                sm_waddr = sm_addr({bank, slot_select}, SCNT_W'(word_index));
                sm_wdata = data_word;
              end else begin
                resp_status_next = srs_pkg::STAT_RANGE;
              end
            end
            srs_pkg::OP_COMMIT: begin
              cm_slot_next = bank_valid[bank] ? ~bank_slot[bank] : 1'b0;
              g_cap_next   = bank_gen[bank] + 32'd1;
              state_next   = srs_pkg::ST_CM_HDR;
            end
            srs_pkg::OP_SCAN: begin
              pass_next    = srs_pkg::PASS_S1;
              copy_en_next = 1'b0;
              hdr_ok_next  = 1'b1;
              crc_next     = srs_pkg::CRC_SEED;
              state_next   = srs_pkg::ST_SC_PASS;
            end
            default: ;
          endcase
        end
      end

      srs_pkg::ST_RD: begin
        resp_rd_next = wb_rdata;
        state_next   = srs_pkg::ST_RESP;
      end

      srs_pkg::ST_RESP: begin
        if (out_free) begin
          resp_load  = 1'b1;
          state_next = srs_pkg::ST_IDLE;
        end
      end

      // commit word marked writing first, then magic, size, generation
      srs_pkg::ST_CM_HDR: begin
        sm_we    = 1'b1;
        cnt_next = cnt_inc;
        case (cnt[1:0])
          2'd0: begin
            sm_waddr = sm_addr(rec_cm, SCNT_W'(srs_pkg::OFF_COMMIT));
            sm_wdata = srs_pkg::REC_WRITING;
            crc_next = srs_pkg::CRC_SEED;
          end
          2'd1: begin
            sm_waddr = sm_addr(rec_cm, SCNT_W'(srs_pkg::OFF_MAGIC));
            sm_wdata = srs_pkg::REC_MAGIC;
            crc_next = srs_pkg::crc_update(crc, srs_pkg::REC_MAGIC);
          end
          2'd2: begin
            sm_waddr = sm_addr(rec_cm, SCNT_W'(srs_pkg::OFF_SIZE));
            sm_wdata = SIZE_WORD;
            crc_next = srs_pkg::crc_update(crc, SIZE_WORD);
          end
          default: begin
            sm_waddr   = sm_addr(rec_cm, SCNT_W'(srs_pkg::OFF_GEN));
            sm_wdata   = g_cap;
            crc_next   = srs_pkg::crc_update(crc, g_cap);
            wb_raddr   = {cur_bank, WB_AW'(0)};
            cnt_next   = '0;
            state_next = srs_pkg::ST_CM_PAY;
          end
        endcase
      end

      srs_pkg::ST_CM_PAY: begin
        sm_we    = 1'b1;
        sm_waddr = sm_addr(rec_cm, cnt + SCNT_W'(srs_pkg::HDR_WORDS));
        sm_wdata = wb_rdata;
        crc_next = srs_pkg::crc_update(crc, wb_rdata);
        wb_raddr = {cur_bank, cnt_inc[WB_AW-1:0]};
        if (cnt == SCNT_W'(PAYLOAD_WORDS - 1)) begin
          cnt_next   = '0;
          state_next = srs_pkg::ST_CM_FIN;
        end else begin
          cnt_next = cnt_inc;
        end
      end

      srs_pkg::ST_CM_FIN: begin
        sm_we = 1'b1;
        if (!cnt[0]) begin
          sm_waddr = sm_addr(rec_cm, SCNT_W'(srs_pkg::OFF_CRC));
          sm_wdata = ~crc;
          cnt_next = cnt_inc;
        end else begin
          sm_waddr         = sm_addr(rec_cm, SCNT_W'(srs_pkg::OFF_COMMIT));
          sm_wdata         = srs_pkg::REC_VALID;
          bank_upd         = 1'b1;
          upd_gen          = g_cap;
          upd_slot         = cm_slot;
          upd_valid        = 1'b1;
          resp_status_next = srs_pkg::STAT_DONE;
          state_next       = srs_pkg::ST_RESP;
        end
      end

      srs_pkg::ST_SC_PASS: begin
        if (cnt < SCNT_W'(SLOT_WORDS)) begin
          sm_raddr     = sm_addr(rec_sc, cnt);
          arr_vld_next = 1'b1;
          arr_off_next = cnt;
          cnt_next     = cnt_inc;
        end
        if (arr_vld) begin
          if (arr_off == SCNT_W'(srs_pkg::OFF_MAGIC)) begin
            hdr_ok_next = hdr_ok && (sm_rdata == srs_pkg::REC_MAGIC);
            crc_next    = srs_pkg::crc_update(crc, sm_rdata);
          end else if (arr_off == SCNT_W'(srs_pkg::OFF_SIZE)) begin
            hdr_ok_next = hdr_ok && (sm_rdata == SIZE_WORD);
            crc_next    = srs_pkg::crc_update(crc, sm_rdata);
          end else if (arr_off == SCNT_W'(srs_pkg::OFF_GEN)) begin
            g_cap_next = sm_rdata;
            crc_next   = srs_pkg::crc_update(crc, sm_rdata);
            // slot 0 payload is copied unless a valid slot 1 is newer
            if (pass == srs_pkg::PASS_S0) begin
              copy_en_next = !(ok1 && (gdiff != 32'd0) && !gdiff[31]);
            end
          end else if (arr_off == SCNT_W'(srs_pkg::OFF_CRC)) begin
            crc_cap_next = sm_rdata;
          end else if (arr_off == SCNT_W'(srs_pkg::OFF_COMMIT)) begin
            hdr_ok_next = hdr_ok && (sm_rdata == srs_pkg::REC_VALID);
          end else begin
            crc_next = srs_pkg::crc_update(crc, sm_rdata);
            if (copy_en) begin
              wb_ctl.we = 1'b1;
              wb_waddr  = {cur_bank, pay_off[WB_AW-1:0]};
              wb_wdata  = sm_rdata;
            end
          end
          if (arr_off == SCNT_W'(SLOT_WORDS - 1)) begin
            state_next = srs_pkg::ST_SC_CHK;
          end
        end
      end

      srs_pkg::ST_SC_CHK: begin
        cnt_next    = '0;
        hdr_ok_next = 1'b1;
        crc_next    = srs_pkg::CRC_SEED;
        case (pass)
          srs_pkg::PASS_S1: begin
            ok1_next     = rec_ok;
            g1_next      = g_cap;
            copy_en_next = 1'b0;
            pass_next    = srs_pkg::PASS_S0;
            state_next   = srs_pkg::ST_SC_PASS;
          end
          srs_pkg::PASS_S0: begin
            if (rec_ok && copy_en) begin
              bank_upd         = 1'b1;
              upd_gen          = g_cap;
              upd_slot         = 1'b0;
              upd_valid        = 1'b1;
              resp_status_next = srs_pkg::STAT_DONE;
              state_next       = srs_pkg::ST_RESP;
            end else if (ok1) begin
              copy_en_next = 1'b1;
              pass_next    = srs_pkg::PASS_CP;
              state_next   = srs_pkg::ST_SC_PASS;
            end else begin
              wb_ctl.clr       = 1'b1;
              wb_ctl.clr_bank  = cur_bank;
              bank_upd         = 1'b1;
              resp_status_next = srs_pkg::STAT_NO_VALID;
              state_next       = srs_pkg::ST_RESP;
            end
          end
          default: begin
            bank_upd         = 1'b1;
            upd_gen          = g1;
            upd_slot         = 1'b1;
            upd_valid        = 1'b1;
            resp_status_next = srs_pkg::STAT_DONE;
            state_next       = srs_pkg::ST_RESP;
          end
        endcase
      end

      default: state_next = srs_pkg::ST_IDLE;
    endcase
  end

  a_scan_read_only: assert property (@(posedge clk) disable iff (rst)
    (state == srs_pkg::ST_SC_PASS || state == srs_pkg::ST_SC_CHK) |-> !sm_we)
    else $error("slot memory written during scan");

  a_wb_write_clear: assert property (@(posedge clk) disable iff (rst)
    !(wb_ctl.we && wb_ctl.clr))
    else $error("working buffer write and clear together");

  a_commit_adopts: assert property (@(posedge clk) disable iff (rst)
    (state == srs_pkg::ST_CM_FIN && cnt[0]) |=>
      (bank_valid[cur_bank] && bank_slot[cur_bank] == $past(cm_slot) &&
       state == srs_pkg::ST_RESP))
    else $error("commit did not adopt its target slot");

  a_pay_range: assert property (@(posedge clk) disable iff (rst)
    state == srs_pkg::ST_CM_PAY |-> cnt < SCNT_W'(PAYLOAD_WORDS))
    else $error("commit payload index out of range");

  a_arr_range: assert property (@(posedge clk) disable iff (rst)
    (state == srs_pkg::ST_SC_PASS && arr_vld) |-> arr_off < SCNT_W'(SLOT_WORDS))
    else $error("scan read beyond slot");

endmodule

// ----- hdl/ab_slot_record_store.sv -----
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: bank, slot_select, word_index,
//                                            data_word; tuser: opcode
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: read_data, generation,
//                                            active_slot; tuser: status
//
// one item at a time; steps from accept to result register:
//   load, raw slot write, unused opcode, out of range: directly; read word: via ST_RD
//   commit: header, payload (one working buffer word per cycle into slot memory), crc
//   scan: a pass over slot 1, one over slot 0, and a copy pass over slot 1 when it wins
//   (one slot memory word per cycle per pass through the synchronous read port)
// synchronous reset clears bank state and working buffer flags; slot memory is retained
// a waiting result does not block the next accept; only a full result register
// that is not taken holds the engine before it returns to idle
module ab_slot_record_store #(
  parameter int PAYLOAD_WORDS = srs_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // bank, slot_select, word_index[6:0], data_word[31:0]
  input  logic [2:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // read_data[31:0], generation[31:0], active_slot
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int SLOT_WORDS = PAYLOAD_WORDS + srs_pkg::HDR_WORDS;
  localparam int SM_AW = srs_pkg::sm_aw(PAYLOAD_WORDS);
  localparam int WB_AW = srs_pkg::wb_aw(PAYLOAD_WORDS);

  // slot memory ports
  logic             sm_we;
  logic [SM_AW-1:0] sm_waddr;
  logic [31:0]      sm_wdata;
  logic [SM_AW-1:0] sm_raddr;
  logic [31:0]      sm_rdata;

  // working buffer ports
  srs_pkg::wb_ctl_t wb_ctl;
  logic [WB_AW:0]   wb_waddr;
  logic [31:0]      wb_wdata;
  logic [WB_AW:0]   wb_raddr;
  logic [31:0]      wb_rdata;

  logic             idle;
  logic             out_free;
  logic             resp_load;
  srs_pkg::resp_t   resp;

  // result register is free when empty or being taken this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = idle;

  srs_engine #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .idle        (idle),
    .opcode      (s_axis_tuser),
    .bank        (s_axis_tdata[0]),
    .slot_select (s_axis_tdata[1]),
    .word_index  (s_axis_tdata[8:2]),
    .data_word   (s_axis_tdata[40:9]),
    .out_free    (out_free),
    .resp_load   (resp_load),
    .resp        (resp),
    .sm_we       (sm_we),
    .sm_waddr    (sm_waddr),
    .sm_wdata    (sm_wdata),
    .sm_raddr    (sm_raddr),
    .sm_rdata    (sm_rdata),
    .wb_ctl      (wb_ctl),
    .wb_waddr    (wb_waddr),
    .wb_wdata    (wb_wdata),
    .wb_raddr    (wb_raddr),
    .wb_rdata    (wb_rdata)
  );

  // four slots of SLOT_WORDS words each, bank-major
  srs_ram #(
    .WIDTH(srs_pkg::WORD_W),
    .DEPTH(4 * SLOT_WORDS)
  ) u_slot_mem (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  // both banks' working buffers, zero until written
  srs_wbuf #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) u_wbuf (
    .clk   (clk),
    .rst   (rst),
    .ctl   (wb_ctl),
    .waddr (wb_waddr),
    .wdata (wb_wdata),
    .raddr (wb_raddr),
    .rdata (wb_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (resp_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      m_axis_tdata <= {7'd0, resp.active_slot, resp.generation, resp.read_data};
      m_axis_tuser <= resp.status;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import srs_pkg::*;

  localparam int PW = PAYLOAD_WORDS_DEF;
  localparam int SLOT_WORDS = PW + HDR_WORDS;
  localparam logic [31:0] SIZE_WORD = {16'(PW * 4), REC_VERSION};
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 3 * (PW + 7) + 32;
  localparam int HOLD_CYCLES = 800;

  typedef struct packed {
    status_t     status;
    logic [31:0] rd;
    logic [31:0] gen;
    logic        slot;
  } reply_t;

  typedef struct {
    logic [2:0]  op;
    bit          bank;
    bit          sel;
    logic [6:0]  idx;
    logic [31:0] data;
    bit          seal;
    bit          pinned;
    reply_t      pin;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // bank, slot_select, word_index[6:0], data_word[31:0]
  logic [2:0]  s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;   // read_data[31:0], generation[31:0], active_slot
  logic [1:0]  m_axis_tuser;   // status

  ab_slot_record_store #(.PAYLOAD_WORDS(PW)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the record store
  logic [31:0] slot_store [4][SLOT_WORDS];
  logic [31:0] wbuf [2][PW];
  logic [31:0] bank_gen [2];
  bit          bank_act [2];
  bit          bank_ok [2];

  reply_t    replies_due [$];
  stim_row_t directed_rows [$];

  int errors, items_sent, results_taken, burst_left, quiet;
  int commits_seen, scans_seen, scans_slot1, scans_empty, forged;
  int rx_mode, rx_phase, hold_left, holds_done;
  reply_t want;

  // reflected crc, one data bit per step, lsb first
  function automatic logic [31:0] crc_fold(logic [31:0] c, logic [31:0] w);
    logic fb;
    for (int i = 0; i < 32; i++) begin
      fb = c[0] ^ w[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // crc a slot should carry for its current generation and payload
  function automatic logic [31:0] sealed_crc(int s);
    logic [31:0] c;
    c = crc_fold(CRC_SEED, REC_MAGIC);
    c = crc_fold(c, SIZE_WORD);
    c = crc_fold(c, slot_store[s][OFF_GEN]);
    for (int i = 0; i < PW; i++) c = crc_fold(c, slot_store[s][HDR_WORDS + i]);
    return ~c;
  endfunction

  function automatic bit slot_sealed(int s);
    return slot_store[s][OFF_COMMIT] == REC_VALID && slot_store[s][OFF_MAGIC] == REC_MAGIC &&
           slot_store[s][OFF_SIZE] == SIZE_WORD && slot_store[s][OFF_CRC] == sealed_crc(s);
  endfunction

  function automatic reply_t record_store_step(logic [2:0] op, bit b, bit sel,
                                               logic [6:0] idx, logic [31:0] d);
    reply_t r;
    int base;
    int tgt;
    logic [31:0] diff;
    r = '0;
    r.status = STAT_DONE;
    case (op)
      OP_LOAD: begin
        if (idx < PW) wbuf[b][idx] = d;
        else r.status = STAT_RANGE;
      end
      OP_COMMIT: begin
        tgt = bank_ok[b] ? int'(!bank_act[b]) : 0;
        base = b * 2 + tgt;
        slot_store[base][OFF_COMMIT] = REC_WRITING;
        slot_store[base][OFF_MAGIC] = REC_MAGIC;
        slot_store[base][OFF_SIZE] = SIZE_WORD;
        slot_store[base][OFF_GEN] = bank_gen[b] + 32'd1;
        for (int i = 0; i < PW; i++) slot_store[base][HDR_WORDS + i] = wbuf[b][i];
        slot_store[base][OFF_CRC] = sealed_crc(base);
        slot_store[base][OFF_COMMIT] = REC_VALID;
        bank_gen[b] = bank_gen[b] + 32'd1;
        bank_act[b] = tgt[0];
        bank_ok[b] = 1'b1;
        commits_seen++;
      end
      OP_SCAN: begin
        bank_ok[b] = 1'b0;
        bank_gen[b] = '0;
        bank_act[b] = 1'b0;
        for (int i = 0; i < PW; i++) wbuf[b][i] = '0;
        for (int k = 0; k < 2; k++) begin
          base = b * 2 + k;
          if (slot_sealed(base)) begin
            diff = slot_store[base][OFF_GEN] - bank_gen[b];
            // serial comparison: newer only if the signed difference is positive
            if (!bank_ok[b] || (diff != 0 && !diff[31])) begin
              for (int i = 0; i < PW; i++) wbuf[b][i] = slot_store[base][HDR_WORDS + i];
              bank_gen[b] = slot_store[base][OFF_GEN];
              bank_act[b] = k[0];
              bank_ok[b] = 1'b1;
            end
          end
        end
        scans_seen++;
        if (!bank_ok[b]) begin
          r.status = STAT_NO_VALID;
          scans_empty++;
        end else if (bank_act[b]) begin
          scans_slot1++;
        end
      end
      OP_READ: begin
        if (idx < PW) r.rd = wbuf[b][idx];
        else r.status = STAT_RANGE;
      end
      OP_RAW: begin
        if (idx < SLOT_WORDS) slot_store[b * 2 + sel][idx] = d;
        else r.status = STAT_RANGE;
      end
      default: ;
    endcase
    r.gen = bank_gen[b];
    r.slot = bank_act[b];
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offer one item in bursts with random gaps; predict it once accepted
  task automatic issue(input logic [2:0] op, input bit b, input bit sel,
                       input logic [6:0] idx, input logic [31:0] d,
                       input bit pinned = 1'b0, input reply_t pin = '0);
    reply_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, d, idx, sel, b};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    r = record_store_step(op, b, sel, idx, d);
    replies_due.push_back(pinned ? pin : r);
    if (op <= OP_RAW) items_sent++;
  endtask

  task automatic add_pinned(input logic [2:0] op, input bit b, input bit sel,
                            input logic [6:0] idx, input logic [31:0] d, input status_t st,
                            input logic [31:0] rd, input logic [31:0] gen, input bit slot);
    stim_row_t row;
    row.op = op;
    row.bank = b;
    row.sel = sel;
    row.idx = idx;
    row.data = d;
    row.seal = 1'b0;
    row.pinned = 1'b1;
    row.pin.status = st;
    row.pin.rd = rd;
    row.pin.gen = gen;
    row.pin.slot = slot;
    directed_rows.push_back(row);
  endtask

  task automatic add_predicted(input logic [2:0] op, input bit b, input bit sel,
                               input logic [6:0] idx, input logic [31:0] d,
                               input bit seal = 1'b0);
    stim_row_t row;
    row.op = op;
    row.bank = b;
    row.sel = sel;
    row.idx = idx;
    row.data = d;
    row.seal = seal;
    row.pinned = 1'b0;
    row.pin = '0;
    directed_rows.push_back(row);
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      if (replies_due.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] != want.rd) begin
          $error("read_data: expected %h, got %h", want.rd, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] != want.gen) begin
          $error("generation: expected %h, got %h", want.gen, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tdata[64] != want.slot) begin
          $error("active_slot: expected %0d, got %0d", want.slot, m_axis_tdata[64]);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if ((holds_done == 0 && results_taken >= 300) ||
                 (holds_done == 1 && results_taken >= 1100)) begin
      // long hold-off: the block fills up and stalls its input
      holds_done++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_phase = $urandom_range(16, 96);
        rx_mode = $urandom_range(0, 3);
      end
      rx_phase--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int b, s, n, directed_count;
    logic [31:0] g, other, d;
    logic [6:0] idx;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_LOAD;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < SLOT_WORDS; j++) slot_store[i][j] = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < PW; j++) wbuf[i][j] = '0;
      bank_gen[i] = '0;
      bank_act[i] = 1'b0;
      bank_ok[i] = 1'b0;
    end

    // after reset, index extremes, out of range codes
    add_pinned(OP_READ, 0, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd0, 0);
    add_pinned(OP_LOAD, 0, 0, PW - 1, 32'hFFFF_FFFF, STAT_DONE, 32'd0, 32'd0, 0);
    add_pinned(OP_LOAD, 0, 0, PW, 32'h1234_5678, STAT_RANGE, 32'd0, 32'd0, 0);
    add_pinned(OP_LOAD, 1, 1, 7'd127, 32'hFFFF_FFFF, STAT_RANGE, 32'd0, 32'd0, 0);
    add_pinned(OP_READ, 0, 0, PW - 1, 32'd0, STAT_DONE, 32'hFFFF_FFFF, 32'd0, 0);
    add_pinned(OP_READ, 1, 0, PW, 32'd0, STAT_RANGE, 32'd0, 32'd0, 0);
    // two commits per bank write every slot before any scan
    add_pinned(OP_COMMIT, 0, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd1, 0);
    add_pinned(OP_COMMIT, 0, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd2, 1);
    add_pinned(OP_COMMIT, 1, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd1, 0);
    add_pinned(OP_COMMIT, 1, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd2, 1);
    // unused opcodes change nothing
    add_pinned(OP_UNUSED_LO, 0, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd2, 1);
    add_pinned(OP_UNUSED_HI, 1, 1, 7'd127, 32'hFFFF_FFFF, STAT_DONE, 32'd0, 32'd2, 1);
    // corrupt the last payload word of the newer slot
    add_pinned(OP_RAW, 0, 1, SLOT_WORDS - 1, 32'hA5A5_A5A5, STAT_DONE, 32'd0, 32'd2, 1);
    add_pinned(OP_RAW, 0, 0, SLOT_WORDS, 32'd0, STAT_RANGE, 32'd0, 32'd2, 1);
    add_pinned(OP_RAW, 1, 1, 7'd127, 32'hFFFF_FFFF, STAT_RANGE, 32'd0, 32'd2, 1);
    // scan falls back to the older slot
    add_predicted(OP_SCAN, 0, 0, 0, 32'd0);
    add_predicted(OP_READ, 0, 0, PW - 1, 32'd0);
    // rebuild slot 1 as a copy of slot 0: equal generations keep slot 0
    add_predicted(OP_RAW, 0, 1, SLOT_WORDS - 1, 32'hFFFF_FFFF);
    add_predicted(OP_RAW, 0, 1, OFF_GEN, 32'd1);
    add_predicted(OP_RAW, 0, 1, OFF_CRC, 32'd0, 1'b1);
    add_predicted(OP_SCAN, 0, 0, 0, 32'd0);
    // interrupted commit word and broken magic: no valid slot left
    add_predicted(OP_RAW, 1, 0, OFF_COMMIT, REC_WRITING);
    add_predicted(OP_RAW, 1, 1, OFF_MAGIC, 32'd0);
    add_pinned(OP_LOAD, 1, 0, 0, 32'h0BAD_F00D, STAT_DONE, 32'd0, 32'd2, 1);
    add_pinned(OP_SCAN, 1, 0, 0, 32'd0, STAT_NO_VALID, 32'd0, 32'd0, 0);
    add_pinned(OP_READ, 1, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd0, 0);
    add_pinned(OP_COMMIT, 1, 0, 0, 32'd0, STAT_DONE, 32'd0, 32'd1, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      d = row.seal ? sealed_crc(row.bank * 2 + row.sel) : row.data;
      issue(row.op, row.bank, row.sel, row.idx, d, row.pinned, row.pin);
    end
    directed_count = items_sent;

    while (items_sent < directed_count + RANDOM_ITEMS) begin
      b = $urandom_range(0, 1);
      s = $urandom_range(0, 1);
      n = $urandom_range(0, 99);
      if (n < 45) begin
        // update: a few loads, commit, maybe scan, read back
        repeat ($urandom_range(1, 6)) issue(OP_LOAD, b, $urandom, $urandom_range(0, PW - 1),
                                            pick_word());
        issue(OP_COMMIT, b, $urandom, $urandom, pick_word());
        if ($urandom_range(0, 1)) issue(OP_SCAN, b, $urandom, $urandom, pick_word());
        repeat ($urandom_range(1, 3)) issue(OP_READ, b, $urandom, $urandom_range(0, PW - 1),
                                            pick_word());
      end else if (n < 60) begin
        // forged header with a chosen generation against the other slot
        other = slot_store[b * 2 + (s ^ 1)][OFF_GEN];
        case ($urandom_range(0, 5))
          0: g = other;
          1: g = other + 32'd1;
          2: g = other + 32'h7FFF_FFFF;
          3: g = other + 32'h8000_0000;
          4: g = 32'hFFFF_FFFF;
          default: g = $urandom;
        endcase
        issue(OP_RAW, b, s, OFF_MAGIC, REC_MAGIC);
        issue(OP_RAW, b, s, OFF_SIZE, SIZE_WORD);
        issue(OP_RAW, b, s, OFF_COMMIT, REC_VALID);
        issue(OP_RAW, b, s, OFF_GEN, g);
        d = sealed_crc(b * 2 + s);
        if ($urandom_range(0, 5) == 0) d = d ^ (32'd1 << $urandom_range(0, 31));
        issue(OP_RAW, b, s, OFF_CRC, d);
        forged++;
        issue(OP_SCAN, b, $urandom, $urandom, pick_word());
        issue(OP_READ, b, $urandom, $urandom_range(0, PW - 1), pick_word());
        if ($urandom_range(0, 1)) issue(OP_COMMIT, b, $urandom, $urandom, pick_word());
      end else if (n < 70) begin
        // single bit flip or random word anywhere in a slot, then scan
        idx = $urandom_range(0, SLOT_WORDS - 1);
        d = $urandom_range(0, 1) ? (slot_store[b * 2 + s][idx] ^ (32'd1 << $urandom_range(0, 31)))
                                 : pick_word();
        issue(OP_RAW, b, s, idx, d);
        issue(OP_SCAN, b, $urandom, $urandom, pick_word());
      end else if (n < 85) begin
        // noise over the whole field ranges
        issue($urandom_range(0, 7), b, s, $urandom_range(0, 127), pick_word());
      end else begin
        issue(OP_READ, b, s, $urandom_range(0, 127), pick_word());
      end
    end
    s_axis_tvalid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items driven (%0d directed): %0d commits, %0d scans, %0d adopting slot 1,",
             items_sent, directed_count, commits_seen, scans_seen, scans_slot1);
    $display("%0d scans with no record, %0d forged headers, %0d receiver hold-offs",
             scans_empty, forged, holds_done);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/srs_pkg.sv
hdl/srs_ram.sv
hdl/srs_wbuf.sv
hdl/srs_engine.sv
hdl/ab_slot_record_store.sv
tb/tb.sv
